### rtl/sse_pkg.sv
// sse_pkg: shared constants and types of the selection sort engine
// no dependencies; compiled first
`default_nettype none

package sse_pkg;

  localparam int MAX_ITEMS_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // control from the sequencer to the shared compare unit
  typedef struct packed {
    logic start;
    logic rd_valid;
    logic taken;
  } scan_ctl_t;

endpackage

`default_nettype wire

### rtl/sse_in_if.sv
// sse_in_if: valid/ready channel carrying one element of the set per beat
// depends on sse_pkg
`default_nettype none

interface sse_in_if import sse_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] value;
  logic                  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

### rtl/sse_out_if.sv
// sse_out_if: valid/ready channel carrying one sorted element per beat
// depends on sse_pkg
`default_nettype none

interface sse_out_if import sse_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] value_res;
  logic                  last_res;
  logic                  overflowed;

  modport source (output valid, output value_res, output last_res, output overflowed,
                  input ready);
  modport sink   (input valid, input value_res, input last_res, input overflowed,
                  output ready);
endinterface

`default_nettype wire

### rtl/selection_sort_engine_core.sv
// selection_sort_engine_core: loads a set of signed elements, then emits them ascending
// throughput: one element is loaded per cycle; after the last beat each result needs a
// scan pass reading every stored entry through one read port and one comparator, then a
// drain state and an emit state that waits for the output; input is not ready while a
// set is being sorted. reset clears the sequencer, count, overflow flag and
// taken marks at once; the element store is not cleared; uses sse_pkg, sse_ram, sse_min_unit
`default_nettype none

module selection_sort_engine_core import sse_pkg::*; #(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  sse_in_if.sink   in_i,
  sse_out_if.source out_o
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]            state_q;
  logic [CW-1:0]         count_q;
  logic                  ovf_q;
  logic [MAX_ITEMS-1:0]  taken_q;
  logic [IW-1:0]         scan_idx_q;
  logic [IW-1:0]         emit_k_q;
  logic                  rd_valid_q;
  logic [IW-1:0]         rd_idx_q;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_value_q;
  logic                  out_last_q;
  logic                  out_ovf_q;

  logic                  full;
  logic                  in_fire;
  logic                  out_fire;
  logic                  emit_go;
  logic                  final_emit;
  logic [CW-1:0]         n_minus1;
  logic [IW-1:0]         last_idx;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] best_value;
  logic [IW-1:0]         best_idx;
  logic                  found;
  scan_ctl_t             ctl;

  assign full       = (count_q == CW'(MAX_ITEMS));
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;
  assign emit_go    = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);
  assign n_minus1   = count_q - CW'(1);
  assign last_idx   = n_minus1[IW-1:0];
  assign final_emit = (emit_k_q == last_idx);

  assign ctl.start    = (in_fire && in_i.last) || (emit_go && !final_emit);
  assign ctl.rd_valid = rd_valid_q;
  assign ctl.taken    = taken_q[rd_idx_q];

  sse_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_fire && !full),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (in_i.value),
    .re_i    (state_q == S_SCAN),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_data)
  );

  sse_min_unit #(
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_WIDTH  (IW)
  ) u_min (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .rd_data_i    (rd_data),
    .rd_idx_i     (rd_idx_q),
    .best_value_o (best_value),
    .best_idx_o   (best_idx),
    .found_o      (found)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      taken_q     <= '0;
      scan_idx_q  <= '0;
      emit_k_q    <= '0;
      rd_valid_q  <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= (state_q == S_SCAN);
      rd_idx_q   <= scan_idx_q;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_fire) begin
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              count_q <= count_q + CW'(1);
            end
            if (in_i.last) begin
              scan_idx_q <= '0;
              emit_k_q   <= '0;
              state_q    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan_idx_q <= scan_idx_q + IW'(1);
          if (scan_idx_q == last_idx) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            if (final_emit) begin
              taken_q  <= '0;
              count_q  <= '0;
              ovf_q    <= 1'b0;
              emit_k_q <= '0;
              state_q  <= S_LOAD;
            end else begin
              taken_q[best_idx] <= 1'b1;
              emit_k_q          <= emit_k_q + IW'(1);
              scan_idx_q        <= '0;
              state_q           <= S_SCAN;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_value_q <= best_value;
      out_last_q  <= final_emit;
      out_ovf_q   <= ovf_q;
    end
  end

  assign in_i.ready       = (state_q == S_LOAD);
  assign out_o.valid      = out_valid_q;
  assign out_o.value_res  = out_value_q;
  assign out_o.last_res   = out_last_q;
  assign out_o.overflowed = out_ovf_q;

  a_emit_has_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> found)
    else $error("emit without a selected entry");

  a_load_marks_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (taken_q == '0))
    else $error("taken marks left set while loading");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CW'(scan_idx_q) < count_q))
    else $error("scan index beyond stored items");

  a_last_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last) |=> (state_q == S_SCAN) && (count_q != '0))
    else $error("last beat did not start a sort");

endmodule

`default_nettype wire

### rtl/sse_ram.sv
// sse_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/sse_min_unit.sv
// sse_min_unit: shared signed compare unit, tracks the smallest untaken entry of a pass
// depends on sse_pkg for scan_ctl_t
`default_nettype none

module sse_min_unit import sse_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX_WIDTH  = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire scan_ctl_t             ctl_i,
  input  wire logic [DATA_WIDTH-1:0] rd_data_i,
  input  wire logic [IDX_WIDTH-1:0]  rd_idx_i,
  output      logic [DATA_WIDTH-1:0] best_value_o,
  output      logic [IDX_WIDTH-1:0]  best_idx_o,
  output      logic                  found_o
);

  logic                  found_q;
  logic [DATA_WIDTH-1:0] best_value_q;
  logic [IDX_WIDTH-1:0]  best_idx_q;
  logic                  take;

  // strict compare keeps the earliest entry on a tie
  assign take = ctl_i.rd_valid && !ctl_i.taken &&
                (!found_q || ($signed(rd_data_i) < $signed(best_value_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.start) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctl_i.start) begin
      best_value_q <= rd_data_i;
      best_idx_q   <= rd_idx_i;
    end
  end

  assign best_value_o = best_value_q;
  assign best_idx_o   = best_idx_q;
  assign found_o      = found_q;

endmodule

`default_nettype wire
